// ===== rtl/ier_pkg.sv =====
// ----------------------------------------------------------------------------
// ier_pkg
// shared constants and the message descriptor type of the echo responder
// ----------------------------------------------------------------------------
package ier_pkg;

    // default buffer depth in words per message
    localparam int MAX_WORDS_DEF = 32;

    // width of the word count field the descriptor carries
    localparam int WCNT_W = 7;

    localparam int WORD_W = 16;
    localparam int IPV4_W = 32;

    // shortest message that can be answered
    localparam int MIN_WORDS = 4;

    localparam logic [7:0]        TYPE_ECHO_REQUEST = 8'd8;
    localparam logic [WORD_W-1:0] SUM_INIT          = 16'hffff;
    localparam logic [WORD_W-1:0] REPLY_HEAD        = 16'h0000;

    // one answered message, handed from the front to the back
    typedef struct packed {
        logic              bank;
        logic [WCNT_W-1:0] count;
        logic [WORD_W-1:0] csum;
        logic [IPV4_W-1:0] addr;
    } desc_t;

endpackage

// ===== rtl/ier_ram.sv =====
// ----------------------------------------------------------------------------
// ier_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ier_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ier_front.sv =====
// ----------------------------------------------------------------------------
// ier_front
// loads message words into a ram bank, keeps both sums, decides on last word
// ----------------------------------------------------------------------------
module ier_front
    import ier_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF,
    parameter int IDX_W     = $clog2(MAX_WORDS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] packet_word,
    input  logic [IPV4_W-1:0] source_address,
    input  logic              last_word,
    output logic              ram_we,
    output logic [IDX_W:0]    ram_waddr,
    output logic [WORD_W-1:0] ram_wdata,
    output logic              desc_push,
    output desc_t             desc,
    input  logic              msg_done
);

    localparam int CNT_W = $clog2(MAX_WORDS + 1);

    // end-around carry add
    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            oc_add = s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
        end
    endfunction

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] total_reg, total_next;
    logic [WORD_W-1:0] body_reg, body_next;
    logic [1:0]        idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic              type_ok_reg, type_ok_next;
    logic [IPV4_W-1:0] addr_reg, addr_next;
    logic              bank_reg, bank_next;
    logic [1:0]        pend_reg, pend_next;

    logic accept;
    logic store;
    logic first;
    logic ok;

    assign full   = (pend_reg == 2'd2);
    assign accept = push && !full;
    assign first  = (idx_reg == 2'd0);
    assign store  = (count_reg < CNT_W'(MAX_WORDS));

    always_comb
    begin
        addr_next    = first ? source_address : addr_reg;
        type_ok_next = first ? (packet_word[15:8] == TYPE_ECHO_REQUEST) : type_ok_reg;
        total_next   = oc_add(total_reg, packet_word);
        body_next    = (idx_reg == 2'd2) ? oc_add(body_reg, packet_word) : body_reg;
        idx_next     = (idx_reg == 2'd2) ? idx_reg : idx_reg + 2'd1;
        count_next   = store ? count_reg + CNT_W'(1) : count_reg;
        ovf_next     = ovf_reg || !store;
        ok = (count_next >= CNT_W'(MIN_WORDS)) && !ovf_next && type_ok_next
             && (total_next == SUM_INIT);
    end

    assign desc_push  = accept && last_word && ok;
    assign desc.bank  = bank_reg;
    assign desc.count = WCNT_W'(count_next);
    assign desc.csum  = ~body_next;
    assign desc.addr  = addr_next;

    assign ram_we    = accept && store;
    assign ram_waddr = {bank_reg, count_reg[IDX_W-1:0]};
    assign ram_wdata = packet_word;

    assign bank_next = desc_push ? !bank_reg : bank_reg;
    assign pend_next = pend_reg + {1'b0, desc_push} - {1'b0, msg_done};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= SUM_INIT;
            body_reg    <= SUM_INIT;
            idx_reg     <= 2'd0;
            ovf_reg     <= 1'b0;
            type_ok_reg <= 1'b0;
            addr_reg    <= '0;
            bank_reg    <= 1'b0;
            pend_reg    <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            bank_reg <= bank_next;
            if (accept)
            begin
                addr_reg    <= addr_next;
                type_ok_reg <= type_ok_next;
                if (last_word)
                begin
                    count_reg <= '0;
                    total_reg <= SUM_INIT;
                    body_reg  <= SUM_INIT;
                    idx_reg   <= 2'd0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    count_reg <= count_next;
                    total_reg <= total_next;
                    body_reg  <= body_next;
                    idx_reg   <= idx_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    // at most two messages own a bank
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("pending message count out of range");

endmodule

// ===== rtl/ier_desc_q.sv =====
// ----------------------------------------------------------------------------
// ier_desc_q
// two-entry queue of message descriptors between front and back
// ----------------------------------------------------------------------------
module ier_desc_q
    import ier_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t din,
    input  logic  pop,
    output logic  empty,
    output desc_t dout
);

    desc_t      ent_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign dout  = ent_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push)
        else $error("descriptor queue overrun");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("descriptor queue underrun");

endmodule

// ===== rtl/ier_back.sv =====
// ----------------------------------------------------------------------------
// ier_back
// walks one descriptor, reads the stored words and fills the result queue
// ----------------------------------------------------------------------------
module ier_back
    import ier_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF,
    parameter int IDX_W     = $clog2(MAX_WORDS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  desc_t             q_desc,
    output logic              q_pop,
    output logic              ram_re,
    output logic [IDX_W:0]    ram_raddr,
    input  logic [WORD_W-1:0] ram_rdata,
    output logic              msg_done,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] reply_word,
    output logic [IPV4_W-1:0] dest_address,
    output logic              reply_last
);

    logic             active_reg;
    desc_t            cur_reg;
    logic [IDX_W-1:0] k_reg;

    // read stage
    logic              s1_v_reg;
    logic              s1_sel_reg;
    logic [WORD_W-1:0] s1_val_reg;
    logic              s1_last_reg;
    logic [IPV4_W-1:0] s1_addr_reg;

    // result queue
    logic [WORD_W-1:0] ow_reg [2];
    logic [IPV4_W-1:0] oa_reg [2];
    logic              ol_reg [2];
    logic              owp_reg;
    logic              orp_reg;
    logic [1:0]        ocnt_reg;

    logic              pop_fire;
    logic [2:0]        used;
    logic              issue;
    logic              is_last;
    logic [WORD_W-1:0] meta_val;
    logic [WORD_W-1:0] s1_word;

    assign empty    = (ocnt_reg == 2'd0);
    assign pop_fire = pop && !empty;
    assign used     = {1'b0, ocnt_reg} + {2'b0, s1_v_reg};
    assign issue    = active_reg && ((used < 3'd2) || ((used == 3'd2) && pop_fire));
    assign is_last  = (WCNT_W'(k_reg) == cur_reg.count - WCNT_W'(1));
    assign q_pop    = !active_reg && !q_empty;
    assign msg_done = issue && is_last;

    assign ram_re    = issue;
    assign ram_raddr = {cur_reg.bank, k_reg};

    assign meta_val = (k_reg == '0) ? REPLY_HEAD : cur_reg.csum;
    assign s1_word  = s1_sel_reg ? ram_rdata : s1_val_reg;

    assign reply_word   = ow_reg[orp_reg];
    assign dest_address = oa_reg[orp_reg];
    assign reply_last   = ol_reg[orp_reg];

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_desc;
        end
        if (issue)
        begin
            s1_sel_reg  <= (k_reg >= IDX_W'(2));
            s1_val_reg  <= meta_val;
            s1_last_reg <= is_last;
            s1_addr_reg <= cur_reg.addr;
        end
        if (s1_v_reg)
        begin
            ow_reg[owp_reg] <= s1_word;
            oa_reg[owp_reg] <= s1_addr_reg;
            ol_reg[owp_reg] <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
            s1_v_reg   <= 1'b0;
            owp_reg    <= 1'b0;
            orp_reg    <= 1'b0;
            ocnt_reg   <= 2'd0;
        end
        else
        begin
            if (q_pop)
            begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end
            else if (issue)
            begin
                if (is_last)
                begin
                    active_reg <= 1'b0;
                end
                k_reg <= k_reg + IDX_W'(1);
            end
            s1_v_reg <= issue;
            if (s1_v_reg)
            begin
                owp_reg <= !owp_reg;
            end
            if (pop_fire)
            begin
                orp_reg <= !orp_reg;
            end
            ocnt_reg <= ocnt_reg + {1'b0, s1_v_reg} - {1'b0, pop_fire};
        end
    end

    // read data always finds a free slot in the result queue
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && (ocnt_reg == 2'd2)) |-> pop_fire)
        else $error("result queue overrun");

    // the last word of a reply ends the walk
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        msg_done |=> !active_reg)
        else $error("walk continued past last word");

endmodule

// ===== rtl/icmp_echo_responder_unit.sv =====
// ----------------------------------------------------------------------------
// icmp_echo_responder_unit
// answers icmp echo requests with echo replies, word by word
// ----------------------------------------------------------------------------
// path: after the last request word the first reply word passes the
//   descriptor queue, walker, read stage and result queue, then reply words
//   follow one per cycle while pop keeps up
// throughput: one request word per cycle in while full is low; a new reply
//   waits on the last; full rises while two answered messages hold the banks
// reset: asynchronous, active low; control state clears at once, no sweep
// ----------------------------------------------------------------------------
module icmp_echo_responder_unit
    import ier_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request side
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] packet_word,
    input  logic [IPV4_W-1:0] source_address,
    input  logic              last_word,
    // reply side
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] reply_word,
    output logic [IPV4_W-1:0] dest_address,
    output logic              reply_last
);

    // word index within one bank, plus one bank select bit on top
    localparam int IDX_W     = $clog2(MAX_WORDS);
    localparam int RAM_AW    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic  desc_push;
    desc_t desc_in;
    logic  desc_pop;
    logic  desc_empty;
    desc_t desc_out;
    logic  msg_done;

    // front: takes each word transfer, writes it to the current bank while the
    // bank has room and updates both ones-complement sums; on the last word a
    // good message becomes a descriptor and the bank flips
    ier_front #(
        .MAX_WORDS (MAX_WORDS),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .packet_word    (packet_word),
        .source_address (source_address),
        .last_word      (last_word),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .desc_push      (desc_push),
        .desc           (desc_in),
        .msg_done       (msg_done)
    );

    // message buffer, two banks of 2**IDX_W words, MAX_WORDS used in each
    ier_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // short queue decoupling the loader from the reply walker
    ier_desc_q u_desc_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .din   (desc_in),
        .pop   (desc_pop),
        .empty (desc_empty),
        .dout  (desc_out)
    );

    // back: header word, checksum word, then the copied words from the ram;
    // releases the bank once its last word has been read
    ier_back #(
        .MAX_WORDS (MAX_WORDS),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (desc_empty),
        .q_desc       (desc_out),
        .q_pop        (desc_pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .msg_done     (msg_done),
        .empty        (empty),
        .pop          (pop),
        .reply_word   (reply_word),
        .dest_address (dest_address),
        .reply_last   (reply_last)
    );

endmodule
